// File: sv/u16u8_pkg.sv
// ----------------------------------------------------------------------------
// u16u8_pkg
// Types and constants shared by the UTF-16 to UTF-8 encoder modules.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  // Code unit classification masks and patterns
  localparam logic [15:0] ASCII_MASK     = 16'hFF80;
  localparam logic [15:0] TWO_BYTE_MASK  = 16'hF800;
  localparam logic [15:0] SURR_MASK      = 16'hFC00;
  localparam logic [15:0] HIGH_SURR_PAT  = 16'hD800;
  localparam logic [15:0] LOW_SURR_PAT   = 16'hDC00;

  // UTF-8 lead and continuation markers
  localparam logic [7:0] LEAD2_MARK = 8'hC0;
  localparam logic [7:0] CONT_MARK  = 8'h80;
  localparam logic [7:0] LEAD4_MARK = 8'hF0;
  localparam logic [7:0] LEAD3_MARK = 8'hE0;
  localparam logic [7:0] CONT_MASK  = 8'h3F;

  localparam int unsigned JOB_BYTES = 6;
  localparam int unsigned JOB_CNT_W = 3;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] utf8_byte;
    logic       last_of_run;
  } out_item_t;

  // One queued request: the bytes of one input item, first byte at index 0
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [JOB_CNT_W-1:0]      count;
  } job_t;

endpackage

// File: sv/u16u8_front.sv
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, tracks the held high surrogate and builds the byte list.
// ----------------------------------------------------------------------------
module u16u8_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  u16u8_pkg::in_item_t in_item,
  output logic                in_stall,
  input  logic                q_full,
  output logic                job_push,
  output u16u8_pkg::job_t     job
);
  import u16u8_pkg::*;

  logic        held_r, held_nxt;
  logic [9:0]  held_bits_r, held_bits_nxt;
  logic [15:0] u;
  logic        eos, accept, is_low, is_high, pair, flush, own_hold;
  logic [2:0][7:0] own_b;
  logic [1:0]  own_cnt;
  logic [15:0] held_unit;
  logic [20:0] cp;

  assign u         = in_item.code_unit;
  assign eos       = in_item.end_of_string;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign is_low    = (u & SURR_MASK) == LOW_SURR_PAT;
  assign is_high   = (u & SURR_MASK) == HIGH_SURR_PAT;
  assign pair      = held_r && is_low;
  assign flush     = held_r && !is_low;
  assign held_unit = HIGH_SURR_PAT | {6'd0, held_bits_r};
  assign cp        = {1'b0, held_bits_r, u[9:0]} + 21'h10000;

  // Bytes of the unit itself
  always_comb begin
    own_b    = '0;
    own_cnt  = 2'd0;
    own_hold = 1'b0;
    if (u == 16'd0) begin
      own_cnt = 2'd0;
    end else if ((u & ASCII_MASK) == 16'd0) begin
      own_b[0] = u[7:0];
      own_cnt  = 2'd1;
    end else if ((u & TWO_BYTE_MASK) == 16'd0) begin
      own_b[0] = LEAD2_MARK | {3'd0, u[10:6]};
      own_b[1] = CONT_MARK | {2'd0, u[5:0]};
      own_cnt  = 2'd2;
    end else if (is_high && !eos) begin
      own_hold = 1'b1;
    end else begin
      own_b[0] = LEAD3_MARK | {4'd0, u[15:12]};
      own_b[1] = CONT_MARK | {2'd0, u[11:6]};
      own_b[2] = CONT_MARK | {2'd0, u[5:0]};
      own_cnt  = 2'd3;
    end
  end

  // Assemble the request: pair, flushed unit plus own bytes, or own bytes
  always_comb begin
    job = '0;
    if (pair) begin
      job.bytes[0] = LEAD4_MARK | {5'd0, cp[20:18]};
      job.bytes[1] = CONT_MARK | {2'd0, cp[17:12]};
      job.bytes[2] = CONT_MARK | {2'd0, cp[11:6]};
      job.bytes[3] = CONT_MARK | {2'd0, cp[5:0]};
      job.count    = JOB_CNT_W'(4);
    end else if (flush) begin
      job.bytes[0] = LEAD3_MARK | {4'd0, held_unit[15:12]};
      job.bytes[1] = CONT_MARK | {2'd0, held_unit[11:6]};
      job.bytes[2] = CONT_MARK | {2'd0, held_unit[5:0]};
      job.bytes[3] = own_b[0];
      job.bytes[4] = own_b[1];
      job.bytes[5] = own_b[2];
      job.count    = JOB_CNT_W'(3) + JOB_CNT_W'(own_cnt);
    end else begin
      job.bytes[0] = own_b[0];
      job.bytes[1] = own_b[1];
      job.bytes[2] = own_b[2];
      job.count    = JOB_CNT_W'(own_cnt);
    end
  end

  assign job_push = accept && (job.count != '0);

  always_comb begin
    held_nxt      = held_r;
    held_bits_nxt = held_bits_r;
    if (accept) begin
      held_nxt      = own_hold && !pair;
      held_bits_nxt = u[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= 1'b0;
      held_bits_r <= '0;
    end else begin
      held_r      <= held_nxt;
      held_bits_r <= held_bits_nxt;
    end
  end

  a_eos_clears_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && eos) |=> !held_r)
    else $error("held surrogate survived end of string");

  a_hold_needs_high: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !held_r && !is_high) |=> !held_r)
    else $error("hold set by a non-surrogate unit");

endmodule

// File: sv/u16u8_queue.sv
// ----------------------------------------------------------------------------
// u16u8_queue
// Small request queue between the classifier and the byte serializer.
// ----------------------------------------------------------------------------
module u16u8_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  u16u8_pkg::job_t push_job,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output u16u8_pkg::job_t q_job
);
  import u16u8_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full    = cnt_r == CNT_W'(DEPTH);
  assign q_valid = cnt_r != '0;
  assign q_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> !pop)
    else $error("pop from empty queue");

endmodule

// File: sv/u16u8_back.sv
// ----------------------------------------------------------------------------
// u16u8_back
// Serializes queued requests, one UTF-8 byte per cycle unless out_stall holds.
// ----------------------------------------------------------------------------
module u16u8_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  u16u8_pkg::job_t      q_job,
  output logic                 pop,
  output logic                 out_valid,
  output u16u8_pkg::out_item_t out_item,
  input  logic                 out_stall
);
  import u16u8_pkg::*;

  job_t                 job_r, job_nxt;
  logic [JOB_CNT_W-1:0] idx_r, idx_nxt;
  logic                 busy_r, busy_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_r, out_nxt;
  logic                 adv, cur_last;

  assign adv       = !out_valid_r || !out_stall;
  assign cur_last  = idx_r == (job_r.count - JOB_CNT_W'(1));
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    job_nxt       = job_r;
    idx_nxt       = idx_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    pop           = 1'b0;
    if (adv) begin
      if (busy_r) begin
        out_valid_nxt         = 1'b1;
        out_nxt.utf8_byte     = job_r.bytes[idx_r];
        out_nxt.last_of_run   = cur_last;
        if (cur_last) begin
          // reload at once so bytes keep flowing
          pop      = q_valid;
          job_nxt  = q_job;
          idx_nxt  = '0;
          busy_nxt = q_valid;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end else begin
        out_valid_nxt = 1'b0;
        pop           = q_valid;
        job_nxt       = q_job;
        idx_nxt       = '0;
        busy_nxt      = q_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    out_r <= out_nxt;
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r < job_r.count))
    else $error("byte index past request length");

  a_pop_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (!busy_r || (adv && cur_last)))
    else $error("request popped while serializer busy");

endmodule

// File: sv/utf16_to_utf8_encoder_unit.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder_unit
// UTF-16 code units in, UTF-8 bytes out, surrogate pairs combined.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                       Moves
//  -------  --------------------------  ---------------------------------------
//  in       in_valid in_stall in_item   one code unit and its end-of-string flag
//  out      out_valid out_stall out_item one UTF-8 byte, last_of_run on its end
//
//  Each byte passes through the output register. A unit yields 1 to 3 bytes,
//  4 for a surrogate pair, up to 6 when a held high surrogate is flushed
//  ahead of a new unit; a held surrogate or a terminator yields none.
//  The front accepts a unit in any cycle the request queue has room;
//  the serializer sets the sustained rate of one byte per cycle while
//  out_stall is low. The first byte of a unit passes through the queue,
//  the serializer's request register and the output register.
//  Reset drops any held surrogate, empties the queue and clears out_valid.
//  out_stall holds the output byte; the queue absorbs QUEUE_DEPTH requests
//  before in_stall rises.
//
module utf16_to_utf8_encoder_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  u16u8_pkg::in_item_t  in_item,
  output logic                 in_stall,
  output logic                 out_valid,
  output u16u8_pkg::out_item_t out_item,
  input  logic                 out_stall
);
  import u16u8_pkg::*;

  logic job_push, q_full, q_valid, q_pop;
  job_t push_job, q_job;

  // Classify each unit and build its byte list; holds the pending high surrogate
  u16u8_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .q_full   (q_full),
    .job_push (job_push),
    .job      (push_job)
  );

  // Decouple the classifier from the byte stream
  u16u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  // Walk requests into the output register, one byte per cycle unless stalled
  u16u8_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall)
  );

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-16 to UTF-8 encoder unit.
// A directed table of code units (plain, two- and three-byte, surrogate pairs,
// lone and flushed surrogates, terminators) runs first, then random strings
// built mostly from well-formed sequences. Every request is also fed to a
// local encoder model, and each output byte is checked against the oldest
// expected byte. Both channels see random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import u16u8_pkg::*;

  localparam int unsigned RANDOM_UNITS  = 400;
  localparam int unsigned QUIET_LIMIT   = 2000;  // cycles with no handshake at all
  localparam int unsigned LONG_HOLD     = 120;   // receiver hold-off, in cycles
  localparam int unsigned HOLD_AFTER    = 150;   // requests taken before the hold-off
  localparam int unsigned DRAIN_CYCLES  = 8;

  // One row of the directed table. Rows with typed set carry their expected
  // bytes (first byte in bytes[0]); other rows take theirs from the model.
  typedef struct packed {
    logic [15:0]     unit;
    logic            eos;
    logic            typed;
    logic [2:0]      nbytes;
    logic [0:5][7:0] bytes;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [25] = '{
    '{16'h0041, 1'b0, 1'b1, 3'd1, 48'h41_00_00_00_00_00},  // plain ASCII
    '{16'h0000, 1'b1, 1'b1, 3'd0, 48'h00_00_00_00_00_00},  // terminator, nothing held
    '{16'h007F, 1'b0, 1'b1, 3'd1, 48'h7F_00_00_00_00_00},  // top of one-byte range
    '{16'h0080, 1'b0, 1'b1, 3'd2, 48'hC2_80_00_00_00_00},  // bottom of two-byte range
    '{16'h07FF, 1'b0, 1'b1, 3'd2, 48'hDF_BF_00_00_00_00},  // top of two-byte range
    '{16'h0800, 1'b0, 1'b1, 3'd3, 48'hE0_A0_80_00_00_00},  // bottom of three-byte range
    '{16'hFFFF, 1'b0, 1'b1, 3'd3, 48'hEF_BF_BF_00_00_00},  // all ones
    '{16'hD83D, 1'b0, 1'b1, 3'd0, 48'h00_00_00_00_00_00},  // high half goes on hold
    '{16'hDE00, 1'b0, 1'b1, 3'd4, 48'hF0_9F_98_80_00_00},  // pair -> U+1F600
    '{16'hD800, 1'b0, 1'b1, 3'd0, 48'h00_00_00_00_00_00},
    '{16'hDC00, 1'b0, 1'b1, 3'd4, 48'hF0_90_80_80_00_00},  // lowest pair, U+10000
    '{16'hDBFF, 1'b0, 1'b1, 3'd0, 48'h00_00_00_00_00_00},
    '{16'hDFFF, 1'b1, 1'b1, 3'd4, 48'hF4_8F_BF_BF_00_00},  // highest pair, end flag idle
    '{16'hD800, 1'b0, 1'b0, 3'd0, 48'h0},
    '{16'h0041, 1'b0, 1'b0, 3'd0, 48'h0},                  // unpaired: spill, then ASCII
    '{16'hDBFF, 1'b0, 1'b0, 3'd0, 48'h0},
    '{16'hFFFF, 1'b0, 1'b0, 3'd0, 48'h0},                  // spill plus three bytes: six
    '{16'hD812, 1'b1, 1'b0, 3'd0, 48'h0},                  // high half with end flag
    '{16'hDC80, 1'b0, 1'b0, 3'd0, 48'h0},                  // lone low half
    '{16'hDA00, 1'b0, 1'b0, 3'd0, 48'h0},
    '{16'h0000, 1'b0, 1'b0, 3'd0, 48'h0},                  // terminator flushes held half
    '{16'hD900, 1'b0, 1'b0, 3'd0, 48'h0},
    '{16'hD901, 1'b0, 1'b0, 3'd0, 48'h0},                  // high after high: spill, hold
    '{16'h0000, 1'b1, 1'b0, 3'd0, 48'h0},                  // terminator with end flag
    '{16'hDC00, 1'b1, 1'b0, 3'd0, 48'h0}                   // lone low half with end flag
  };

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_item;
  logic      out_stall = 1'b0;

  // Encoder model state and scratch for the bytes of one request
  logic [9:0]  pend_hi  = '0;
  logic        pend_ok  = 1'b0;
  logic [7:0]  run_buf [6];
  int unsigned run_len;

  out_item_t   utf8_due [$];   // expected bytes, oldest first
  out_item_t   want;
  int unsigned units_taken  = 0;
  int unsigned bytes_seen   = 0;
  int unsigned pairs_joined = 0;
  int unsigned halves_spilt = 0;
  int unsigned errors       = 0;
  int unsigned burst_left   = 0;
  bit          hold_on      = 1'b0;

  utf16_to_utf8_encoder_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Encoder model
  // --------------------------------------------------------------------------
  function automatic void put_byte(input logic [7:0] b);
    run_buf[run_len] = b;
    run_len++;
  endfunction

  function automatic void put_three(input logic [15:0] v);
    put_byte(LEAD3_MARK | {4'd0, v[15:12]});
    put_byte(CONT_MARK  | {2'd0, v[11:6]});
    put_byte(CONT_MARK  | {2'd0, v[5:0]});
  endfunction

  // Fill run_buf with the bytes one request causes and advance the held half.
  function automatic void encode_unit(input in_item_t req);
    logic [15:0] u;
    logic [20:0] cp;
    u       = req.code_unit;
    run_len = 0;
    if (pend_ok) begin
      if ((u & SURR_MASK) == LOW_SURR_PAT) begin
        // join the pair; the end flag has nothing left to flush
        cp      = 21'h10000 + {pend_hi, u[9:0]};
        pend_ok = 1'b0;
        pend_hi = '0;
        pairs_joined++;
        put_byte(LEAD4_MARK | {5'd0, cp[20:18]});
        put_byte(CONT_MARK  | {2'd0, cp[17:12]});
        put_byte(CONT_MARK  | {2'd0, cp[11:6]});
        put_byte(CONT_MARK  | {2'd0, cp[5:0]});
        return;
      end
      // no partner: spill the held half as three bytes first
      put_three(HIGH_SURR_PAT | {6'd0, pend_hi});
      halves_spilt++;
      pend_ok = 1'b0;
      pend_hi = '0;
    end
    if (u == '0) begin
      // terminator: nothing of its own
    end else if ((u & ASCII_MASK) == '0) begin
      put_byte(u[7:0]);
    end else if ((u & TWO_BYTE_MASK) == '0) begin
      put_byte(LEAD2_MARK | {3'd0, u[10:6]});
      put_byte(CONT_MARK  | {2'd0, u[5:0]});
    end else if ((u & SURR_MASK) == HIGH_SURR_PAT && !req.end_of_string) begin
      pend_hi = u[9:0];
      pend_ok = 1'b1;
    end else begin
      if ((u & 16'hF800) == HIGH_SURR_PAT) halves_spilt++;
      put_three(u);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sender: bursts of back-to-back requests separated by random gaps.
  // Hold each payload until it is taken, then book its expected bytes.
  // --------------------------------------------------------------------------
  task automatic offer(input logic [15:0] unit, input logic eos, input logic typed,
                       input logic [2:0] nbytes, input logic [0:5][7:0] bytes);
    in_item_t    req;
    int unsigned gap;
    req.code_unit     = unit;
    req.end_of_string = eos;
    if (burst_left == 0) begin
      // keep offering without pause while the receiver holds off
      gap        = hold_on ? 0 : $urandom_range(1, 7);
      burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_item  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    encode_unit(req);
    units_taken++;
    // typed rows override the model's bytes; the model state still advances
    if (typed) begin
      run_len = nbytes;
      for (int i = 0; i < nbytes; i++) run_buf[i] = bytes[i];
    end
    for (int i = 0; i < run_len; i++)
      utf8_due.push_back(out_item_t'{utf8_byte: run_buf[i],
                                     last_of_run: (i == run_len - 1)});
  endtask

  task automatic flag_mismatch(input string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall pattern changes with each random phase; once, hold off
  // for a long stretch so the request queue fills and in_stall rises.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int unsigned mode;
    int unsigned phase_left;
    bit          hold_done;
    phase_left = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && units_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_on   = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_on = 1'b0;
      end else begin
        if (phase_left == 0) begin
          mode       = $urandom_range(0, 3);
          phase_left = $urandom_range(20, 80);
        end
        phase_left--;
        case (mode)
          0: out_stall <= 1'b0;                           // free running
          1: out_stall <= ($urandom_range(0, 3) == 0);    // light stalls
          2: out_stall <= ($urandom_range(0, 3) != 0);    // heavy stalls
          default: out_stall <= (phase_left % 3 == 0);    // regular beat
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker: compare each taken byte with the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      bytes_seen++;
      if (utf8_due.size() == 0) begin
        flag_mismatch($sformatf("byte %02h with nothing expected", out_item.utf8_byte));
      end else begin
        want = utf8_due.pop_front();
        if (out_item.utf8_byte !== want.utf8_byte)
          flag_mismatch($sformatf("byte %02h, expected %02h",
                                  out_item.utf8_byte, want.utf8_byte));
        if (out_item.last_of_run !== want.last_of_run)
          flag_mismatch($sformatf("last_of_run %b on byte %02h, expected %b",
                                  out_item.last_of_run, out_item.utf8_byte,
                                  want.last_of_run));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if neither channel moves for too long.
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("[%0t] no handshake for %0d cycles, %0d bytes still due",
             $time, QUIET_LIMIT, utf8_due.size());
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus: reset, directed table, random strings, final flush.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned kind;
    logic [15:0] pick;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < 25; r++)
      offer(DIR_TAB[r].unit, DIR_TAB[r].eos, DIR_TAB[r].typed,
            DIR_TAB[r].nbytes, DIR_TAB[r].bytes);

    while (units_taken < RANDOM_UNITS + 25) begin
      kind = $urandom_range(0, 99);
      if (kind < 22) begin
        offer(16'($urandom_range(1, 16'h007F)), ($urandom_range(0, 7) == 0),
              1'b0, '0, '0);
      end else if (kind < 36) begin
        offer(16'($urandom_range(16'h0080, 16'h07FF)), ($urandom_range(0, 7) == 0),
              1'b0, '0, '0);
      end else if (kind < 50) begin
        // BMP above the two-byte range, skipping the surrogate block
        pick = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(16'h0800, 16'hD7FF))
                                           : 16'($urandom_range(16'hE000, 16'hFFFF));
        offer(pick, ($urandom_range(0, 7) == 0), 1'b0, '0, '0);
      end else if (kind < 75) begin
        // well-formed pair, end flag now and then on the low half
        offer(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0, 1'b0, '0, '0);
        offer(16'($urandom_range(16'hDC00, 16'hDFFF)), ($urandom_range(0, 3) == 0),
              1'b0, '0, '0);
      end else if (kind < 83) begin
        // broken pair: high half followed by anything but a low half
        offer(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0, 1'b0, '0, '0);
        case ($urandom_range(0, 3))
          0:       pick = 16'($urandom_range(0, 16'h007F));
          1:       pick = 16'($urandom_range(16'hD800, 16'hDBFF));
          2:       pick = 16'($urandom_range(16'hE000, 16'hFFFF));
          default: pick = 16'($urandom_range(16'h0080, 16'hD7FF));
        endcase
        offer(pick, 1'($urandom_range(0, 1)), 1'b0, '0, '0);
      end else if (kind < 88) begin
        offer(16'($urandom_range(16'hDC00, 16'hDFFF)), 1'($urandom_range(0, 1)),
              1'b0, '0, '0);
      end else if (kind < 93) begin
        offer(16'h0000, 1'($urandom_range(0, 1)), 1'b0, '0, '0);
      end else if (kind < 96) begin
        offer(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b1, 1'b0, '0, '0);
      end else begin
        offer(16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)),
              1'b0, '0, '0);
      end
    end

    // flush whatever half is still held, then drain
    offer(16'h0000, 1'b1, 1'b0, '0, '0);
    in_valid <= 1'b0;
    while (utf8_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Encoded %0d code units into %0d UTF-8 bytes: %0d surrogate pairs joined,",
             units_taken, bytes_seen, pairs_joined);
    $display("%0d unpaired surrogates written as three bytes, %0d mismatches.",
             halves_spilt, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
